/* rtl/loss_table_interpolator_top_macros.svh */
// Assertion macros used by the checker of this block.
`ifndef LOSS_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define LOSS_TABLE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define LTI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lti_pkg.sv */
package lti_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_CLEAR  = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_QUERY  = 2'd2;
	localparam cmd_t CMD_RSVD   = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// bit-serial multiply and divide, one bit per cycle
	localparam int SERIAL_STEPS = 16;
	localparam int STEP_W       = $clog2(SERIAL_STEPS);

endpackage

/* rtl/lti_ram.sv */
module lti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/loss_table_interpolator_top.sv */
// Calibration table of (frequency, loss) points kept in ascending frequency
// order, with piecewise linear lookup.
// Command channel: a word (cmd, frequency, loss_in) is taken on a clock edge
// where start is high and busy is low. cmd: clear, insert point, query.
// Result channel: done pulses for one cycle with loss_out (signed Q7.8) and
// status (ok, query on empty table, insert into full table). Every command
// gives exactly one result word; the receiver cannot stall, it must take it.
// Command flow, from the accepting edge to the done cycle:
//   clear, unused code, full insert, empty query: done follows in the next cycle (busy stays low)
//   insert: each point above the new one is read and moved up one slot, then
//           the new point is written (by a separate step in slot 0, empty table too)
//   query:  a table walk over the n points in the table, plus, when it
//           interpolates, a bit-serial multiply, a restoring divide and a
//           final add
// One command at a time; every walk step has a read state and a compare
// state because the table RAM has a registered read port. A new command may
// be accepted in the cycle where done is high.
// Reset empties the table; the RAM contents are left as they are, only
// entries below the point count are ever read.
module loss_table_interpolator_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lti_pkg::cmd_t       cmd,
	input  logic [15:0]         frequency,
	input  logic signed [15:0]  loss_in,
	output logic                done,
	output logic signed [15:0]  loss_out,
	output lti_pkg::status_t    status
);

	import lti_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_INS_RD  = 13'b0000000000010,
		S_INS_CHK = 13'b0000000000100,
		S_INS_PUT = 13'b0000000001000,
		S_Q0_RD   = 13'b0000000010000,
		S_Q0      = 13'b0000000100000,
		S_QN_RD   = 13'b0000001000000,
		S_QN      = 13'b0000010000000,
		S_SC_RD   = 13'b0000100000000,
		S_SC      = 13'b0001000000000,
		S_MUL     = 13'b0010000000000,
		S_DIV     = 13'b0100000000000,
		S_FIN     = 13'b1000000000000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       pos_q;
	logic [15:0]         key_f_q;
	logic [15:0]         key_l_q;
	logic [15:0]         prev_f_q;
	logic [15:0]         prev_l_q;
	logic [15:0]         mag_q;
	logic [15:0]         den_q;
	logic                neg_q;
	logic [31:0]         p_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;
	logic [15:0]         loss_out_q;
	status_t             status_q;

	logic                ram_we;
	logic [31:0]         ram_wr_data;
	logic [31:0]         ram_rd_data;
	logic [15:0]         rd_f;
	logic [15:0]         rd_l;

	logic [16:0]         diff;
	logic [16:0]         diff_abs;
	logic [16:0]         mul_sum;
	logic [16:0]         div_t;
	logic [16:0]         div_r;
	logic                div_ge;
	logic [16:0]         quo;
	logic [16:0]         quo_sgn;
	logic [16:0]         interp;
	logic                accept;

	assign accept = start && !busy_q;
	assign rd_f   = ram_rd_data[31:16];
	assign rd_l   = ram_rd_data[15:0];

	// insert writes either a moved-up neighbor or the new point at pos_q
	assign ram_we = (state_q == S_INS_PUT) || (state_q == S_INS_CHK);
	assign ram_wr_data = ((state_q == S_INS_CHK) && (rd_f > key_f_q)) ? ram_rd_data
		: {key_f_q, key_l_q};

	lti_ram #(
		.WIDTH (32),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (pos_q),
		.wr_data (ram_wr_data),
		.rd_addr (addr_q),
		.rd_data (ram_rd_data)
	);

	assign diff     = {rd_l[15], rd_l} - {prev_l_q[15], prev_l_q};
	assign diff_abs = diff[16] ? (17'd0 - diff) : diff;

	// shift-add multiply: low half holds the multiplier bits
	assign mul_sum = {1'b0, p_q[31:16]} + (p_q[0] ? {1'b0, mag_q} : 17'd0);

	// restoring divide: high half is the remainder, quotient shifts in low
	assign div_t  = {p_q[31:16], p_q[15]};
	assign div_r  = div_t - {1'b0, den_q};
	assign div_ge = (div_t >= {1'b0, den_q});

	assign quo     = {1'b0, p_q[15:0]};
	assign quo_sgn = neg_q ? (17'd0 - quo) : quo;
	assign interp  = {prev_l_q[15], prev_l_q} + quo_sgn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			addr_q     <= '0;
			pos_q      <= '0;
			key_f_q    <= '0;
			key_l_q    <= '0;
			prev_f_q   <= '0;
			prev_l_q   <= '0;
			mag_q      <= '0;
			den_q      <= '0;
			neg_q      <= 1'b0;
			p_q        <= '0;
			step_q     <= '0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			loss_out_q <= '0;
			status_q   <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						loss_out_q <= '0;
						status_q   <= ST_OK;
						case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							CMD_INSERT: begin
								if (count_q >= CW'(MAX_POINTS)) begin
									status_q <= ST_FULL;
									done_q   <= 1'b1;
								end else begin
									key_f_q <= frequency;
									key_l_q <= loss_in;
									pos_q   <= count_q[AW-1:0];
									addr_q  <= count_q[AW-1:0] - AW'(1);
									busy_q  <= 1'b1;
									state_q <= (count_q == '0) ? S_INS_PUT : S_INS_RD;
								end
							end
							CMD_QUERY: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									done_q   <= 1'b1;
								end else begin
									key_f_q <= frequency;
									addr_q  <= '0;
									busy_q  <= 1'b1;
									state_q <= S_Q0_RD;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CHK;
				end
				S_INS_CHK: begin
					if (rd_f > key_f_q) begin
						// neighbor moved up one slot this cycle
						pos_q  <= pos_q - AW'(1);
						addr_q <= pos_q - AW'(2);
						state_q <= (pos_q == AW'(1)) ? S_INS_PUT : S_INS_RD;
					end else begin
						count_q <= count_q + CW'(1);
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_Q0_RD: begin
					state_q <= S_Q0;
				end
				S_Q0: begin
					prev_f_q <= rd_f;
					prev_l_q <= rd_l;
					if ((count_q == CW'(1)) || (rd_f >= key_f_q)) begin
						loss_out_q <= rd_l;
						busy_q     <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						addr_q  <= count_q[AW-1:0] - AW'(1);
						state_q <= S_QN_RD;
					end
				end
				S_QN_RD: begin
					state_q <= S_QN;
				end
				S_QN: begin
					if (rd_f <= key_f_q) begin
						loss_out_q <= rd_l;
						busy_q     <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						addr_q  <= AW'(1);
						state_q <= S_SC_RD;
					end
				end
				S_SC_RD: begin
					state_q <= S_SC;
				end
				S_SC: begin
					// the walk stops at the last point at the latest, which lies above the key
					if (rd_f == key_f_q) begin
						loss_out_q <= rd_l;
						busy_q     <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (rd_f > key_f_q) begin
						neg_q   <= diff[16];
						mag_q   <= diff_abs[15:0];
						den_q   <= rd_f - prev_f_q;
						p_q     <= {16'd0, key_f_q - prev_f_q};
						step_q  <= '0;
						state_q <= S_MUL;
					end else begin
						prev_f_q <= rd_f;
						prev_l_q <= rd_l;
						addr_q   <= addr_q + AW'(1);
						state_q  <= S_SC_RD;
					end
				end
				S_MUL: begin
					p_q    <= {mul_sum, p_q[15:1]};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SERIAL_STEPS - 1)) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// product < den * 2^16, so the high half starts below den
					p_q    <= {(div_ge ? div_r[15:0] : div_t[15:0]), p_q[14:0], div_ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SERIAL_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					loss_out_q <= interp[15:0];
					busy_q     <= 1'b0;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign loss_out = loss_out_q;
	assign status   = status_q;

endmodule

/* rtl/lti_checker.sv */
`include "loss_table_interpolator_top_macros.svh"

module lti_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input lti_pkg::cmd_t      cmd,
	input logic               done,
	input logic signed [15:0] loss_out,
	input lti_pkg::status_t   status
);

	import lti_pkg::*;

	logic quick_cmd;

	assign quick_cmd = start && !busy && (cmd == CMD_CLEAR || cmd == CMD_RSVD);

	// clear and the unused code answer on the next cycle with a zero word
	`LTI_ASSERT_NEXT(a_clear_quick, quick_cmd, done && status == ST_OK && loss_out == 16'sd0, "clear or unused command did not answer at once")

	// an error word carries no loss
	`LTI_ASSERT_NOW(a_err_zero, done && status != ST_OK, loss_out == 16'sd0, "error word with nonzero loss")

	// the result word and the end of work coincide
	`LTI_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")

	// work only starts from an accepted command
	`LTI_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start), "busy rose without a command")

endmodule

bind loss_table_interpolator_top lti_checker u_lti_checker (.*);
